// ===== hw/rtl/tss_pkg.sv =====
package tss_pkg;

   // Depth of the subnegotiation store and the widths that follow from it.
   localparam int SUBNEG_DEPTH = 32;
   localparam int CNT_W        = $clog2(SUBNEG_DEPTH + 1);
   localparam int ADDR_W       = $clog2(SUBNEG_DEPTH);
   localparam int IDX_W        = $clog2(SUBNEG_DEPTH + 4);

   // Telnet protocol bytes.
   localparam logic [7:0] B_IAC      = 8'd255;
   localparam logic [7:0] B_SB       = 8'd250;
   localparam logic [7:0] B_SE       = 8'd240;
   localparam logic [7:0] B_WILL     = 8'd251;
   localparam logic [7:0] B_WONT     = 8'd252;
   localparam logic [7:0] B_DO       = 8'd253;
   localparam logic [7:0] B_DONT     = 8'd254;
   localparam logic [7:0] B_GMCP     = 8'd201;
   localparam logic [7:0] B_EOR_CMD  = 8'd239;
   localparam logic [7:0] B_EOR_OPT  = 8'd25;
   localparam logic [7:0] B_TTYPE    = 8'd24;
   localparam logic [7:0] B_CHARSET  = 8'd42;
   localparam logic [7:0] B_SEND     = 8'd1;
   localparam logic [7:0] B_REQUEST  = 8'd1;
   localparam logic [7:0] B_ACCEPTED = 8'd2;
   localparam logic [7:0] B_REJECTED = 8'd3;

   // Event codes.
   localparam logic [3:0] EV_NONE       = 4'd0;
   localparam logic [3:0] EV_EOR        = 4'd1;
   localparam logic [3:0] EV_WILL_GMCP  = 4'd2;
   localparam logic [3:0] EV_DO_GMCP    = 4'd3;
   localparam logic [3:0] EV_DO_EOR     = 4'd4;
   localparam logic [3:0] EV_DONT_EOR   = 4'd5;
   localparam logic [3:0] EV_DO_TTYPE   = 4'd6;
   localparam logic [3:0] EV_DO_CHARSET = 4'd7;
   localparam logic [3:0] EV_TTYPE_SEND = 4'd8;
   localparam logic [3:0] EV_REQUEST    = 4'd9;
   localparam logic [3:0] EV_ACCEPTED   = 4'd10;
   localparam logic [3:0] EV_REJECTED   = 4'd11;

   // Kinds of result job that an accepted byte starts.
   localparam logic [3:0] K_NONE     = 4'd0;
   localparam logic [3:0] K_DATA     = 4'd1;
   localparam logic [3:0] K_IACIAC   = 4'd2;
   localparam logic [3:0] K_CMD2     = 4'd3;
   localparam logic [3:0] K_CMD3     = 4'd4;
   localparam logic [3:0] K_GMCP1    = 4'd5;
   localparam logic [3:0] K_GMCP_IAC = 4'd6;
   localparam logic [3:0] K_GEND     = 4'd7;
   localparam logic [3:0] K_REPLAY   = 4'd8;

   // Store write operations.
   localparam logic [2:0] PUSH_NONE    = 3'd0;
   localparam logic [2:0] PUSH_BYTE    = 3'd1;
   localparam logic [2:0] PUSH_IAC     = 3'd2;
   localparam logic [2:0] PUSH_FIRST   = 3'd3;
   localparam logic [2:0] PUSH_LATCHED = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_chunk;
   } req_type;

   typedef struct packed {
      logic       plain_valid;
      logic [7:0] plain_byte;
      logic       gmcp_valid;
      logic [7:0] gmcp_byte;
      logic       gmcp_end;
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [3:0] event_res;
      logic       chunk_done;
      logic       last_result;
   } rsp_type;

   // Everything needed to produce every result of one item.
   typedef struct packed {
      logic [7:0]       p0;
      logic [7:0]       p1;
      logic [7:0]       p2;
      logic [1:0]       np;
      logic [7:0]       g0;
      logic [7:0]       g1;
      logic [1:0]       ng;
      logic             gend;
      logic [3:0]       ev;
      logic             eoc;
      logic             replay;
      logic             show;
      logic [CNT_W-1:0] cnt;
      logic [CNT_W-1:0] ny;
      logic [IDX_W-1:0] last_idx;
   } job_type;

   typedef struct packed {
      logic       accept;
      logic [3:0] kind;
      logic       hold_cmd;
      logic [2:0] push_op;
      logic       clear_cnt;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic space;
      logic is_iac;
      logic is_sb;
      logic is_se;
      logic is_cmd;
      logic is_gmcp;
      logic multi;
      logic at_last;
   } stat_type;

   // Builds result k of a job. mem_p and mem_y are the store bytes for the
   // replayed stream and the charset payload at this k.
   function automatic rsp_type build_result(job_type j, logic [IDX_W-1:0] k,
                                            logic [7:0] mem_p, logic [7:0] mem_y);
      rsp_type      r;
      logic [IDX_W:0] kx;
      logic [IDX_W:0] cnt2;
      logic         last;
      r    = '0;
      kx   = {1'b0, k};
      cnt2 = (IDX_W+1)'(j.cnt) + (IDX_W+1)'(2);
      last = (k == j.last_idx);
      if (j.replay) begin
         r.plain_valid = j.show;
         if (j.show) begin
            if (kx == (IDX_W+1)'(0)) r.plain_byte = B_IAC;
            else if (kx == (IDX_W+1)'(1)) r.plain_byte = B_SB;
            else if (kx < cnt2) r.plain_byte = mem_p;
            else if (kx == cnt2) r.plain_byte = B_IAC;
            else r.plain_byte = B_SE;
         end
         if (kx < (IDX_W+1)'(j.ny)) begin
            r.payload_valid = 1'b1;
            r.payload_byte  = mem_y;
         end
      end else begin
         if (kx < (IDX_W+1)'(j.np)) begin
            r.plain_valid = 1'b1;
            if (kx == (IDX_W+1)'(0)) r.plain_byte = j.p0;
            else if (kx == (IDX_W+1)'(1)) r.plain_byte = j.p1;
            else r.plain_byte = j.p2;
         end
         if (kx < (IDX_W+1)'(j.ng)) begin
            r.gmcp_valid = 1'b1;
            r.gmcp_byte  = (kx == (IDX_W+1)'(0)) ? j.g0 : j.g1;
         end
         r.gmcp_end = j.gend && (kx == (IDX_W+1)'(0));
      end
      r.event_res   = j.ev;
      r.chunk_done  = last & j.eoc;
      r.last_result = last;
      return r;
   endfunction

endpackage

// ===== hw/rtl/tss_out_fifo.sv =====
module tss_out_fifo import tss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Two entries, so a new result can be written while the head waits.
   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign space     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/tss_datapath.sv =====
module tss_datapath import tss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   input  logic     csr_valid,
   output logic     csr_ready,
   input  logic     csr_data,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   logic [7:0]       mem [SUBNEG_DEPTH];
   logic             strip_ff;
   logic [7:0]       held_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       byte0_ff, byte1_ff;
   logic [7:0]       b_ff;
   job_type          job_ff, job_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       rd_p_ff, rd_y_ff;
   logic [ADDR_W-1:0] addr_p, addr_y;

   logic [7:0]       b;
   logic             do_write;
   logic [CNT_W-1:0] push_addr;
   logic [7:0]       push_byte;
   logic [IDX_W:0]   n_wide;
   logic             fifo_push;
   rsp_type          fifo_data;
   logic             fifo_space;

   assign b         = req_data.data_byte;
   assign csr_ready = 1'b1;

   // Job for the byte on the input, as chosen by the controller.
   always_comb begin
      job_in      = '0;
      job_in.eoc  = req_data.end_of_chunk;
      job_in.show = !strip_ff;
      n_wide      = '0;
      unique case (cmd.kind)
         K_DATA: begin
            job_in.p0 = b;
            job_in.np = 2'd1;
         end
         K_IACIAC: begin
            job_in.p0 = B_IAC;
            job_in.np = 2'd1;
         end
         K_CMD2: begin
            if (b == B_EOR_CMD) job_in.ev = EV_EOR;
            if (!strip_ff) begin
               job_in.p0 = B_IAC;
               job_in.p1 = b;
               job_in.np = 2'd2;
            end
         end
         K_CMD3: begin
            if (b == B_GMCP) begin
               if (held_ff == B_WILL) job_in.ev = EV_WILL_GMCP;
               else if (held_ff == B_DO) job_in.ev = EV_DO_GMCP;
            end else if (b == B_EOR_OPT) begin
               if (held_ff == B_DO) job_in.ev = EV_DO_EOR;
               else if (held_ff == B_DONT) job_in.ev = EV_DONT_EOR;
            end else if (b == B_TTYPE && held_ff == B_DO) begin
               job_in.ev = EV_DO_TTYPE;
            end else if (b == B_CHARSET && held_ff == B_DO) begin
               job_in.ev = EV_DO_CHARSET;
            end
            if (!strip_ff) begin
               job_in.p0 = B_IAC;
               job_in.p1 = held_ff;
               job_in.p2 = b;
               job_in.np = 2'd3;
            end
         end
         K_GMCP1: begin
            job_in.g0 = b;
            job_in.ng = 2'd1;
         end
         K_GMCP_IAC: begin
            job_in.g0 = B_IAC;
            job_in.g1 = b;
            job_in.ng = (b == B_IAC) ? 2'd1 : 2'd2;
         end
         K_GEND: begin
            job_in.gend = 1'b1;
         end
         K_REPLAY: begin
            job_in.replay = 1'b1;
            job_in.cnt    = count_ff;
            if (count_ff >= CNT_W'(2) && byte0_ff == B_TTYPE && byte1_ff == B_SEND) begin
               job_in.ev = EV_TTYPE_SEND;
            end else if (count_ff >= CNT_W'(2) && byte0_ff == B_CHARSET) begin
               if (byte1_ff == B_REQUEST) job_in.ev = EV_REQUEST;
               else if (byte1_ff == B_ACCEPTED) job_in.ev = EV_ACCEPTED;
               else if (byte1_ff == B_REJECTED) job_in.ev = EV_REJECTED;
            end
            if (job_in.ev == EV_REQUEST || job_in.ev == EV_ACCEPTED) begin
               job_in.ny = count_ff - CNT_W'(2);
            end
         end
         default: begin
         end
      endcase
      if (job_in.replay) begin
         if (!strip_ff) n_wide = (IDX_W+1)'(count_ff) + (IDX_W+1)'(4);
         else if (job_in.ny != '0) n_wide = (IDX_W+1)'(job_in.ny);
         else n_wide = (IDX_W+1)'(1);
      end else begin
         n_wide = (IDX_W+1)'(1);
         if ((IDX_W+1)'(job_in.np) > n_wide) n_wide = (IDX_W+1)'(job_in.np);
         if ((IDX_W+1)'(job_in.ng) > n_wide) n_wide = (IDX_W+1)'(job_in.ng);
      end
      job_in.last_idx = IDX_W'(n_wide - (IDX_W+1)'(1));
   end

   // Store writes.
   always_comb begin
      push_addr = count_ff;
      push_byte = b;
      unique case (cmd.push_op)
         PUSH_IAC:     push_byte = B_IAC;
         PUSH_FIRST:   push_addr = '0;
         PUSH_LATCHED: push_byte = b_ff;
         default: begin
         end
      endcase
      do_write = (cmd.push_op != PUSH_NONE) && (push_addr < CNT_W'(SUBNEG_DEPTH));
      if (do_write) count_in = push_addr + CNT_W'(1);
      else if (cmd.clear_cnt) count_in = '0;
      else count_in = count_ff;
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.accept) idx_in = job_in.replay ? IDX_W'(0) : IDX_W'(1);
      else if (cmd.emit) idx_in = idx_ff + IDX_W'(1);
   end

   assign addr_p = ADDR_W'(idx_ff - IDX_W'(2));
   assign addr_y = ADDR_W'(idx_ff + IDX_W'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff <= 1'b1;
         held_ff  <= 8'd0;
         count_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) strip_ff <= csr_data;
         if (cmd.hold_cmd) held_ff <= b;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         b_ff   <= b;
         job_ff <= job_in;
      end
      idx_ff <= idx_in;
      if (do_write && push_addr == CNT_W'(0)) byte0_ff <= push_byte;
      if (do_write && push_addr == CNT_W'(1)) byte1_ff <= push_byte;
   end

   always_ff @(posedge clock) begin
      if (do_write) mem[push_addr[ADDR_W-1:0]] <= push_byte;
      rd_p_ff <= mem[addr_p];
      rd_y_ff <= mem[addr_y];
   end

   assign fifo_push = (cmd.accept && !job_in.replay) || cmd.emit;
   assign fifo_data = cmd.accept ? build_result(job_in, '0, 8'd0, 8'd0)
                                 : build_result(job_ff, idx_ff, rd_p_ff, rd_y_ff);

   tss_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_data),
      .space     (fifo_space),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always_comb begin
      stat.space   = fifo_space;
      stat.is_iac  = (b == B_IAC);
      stat.is_sb   = (b == B_SB);
      stat.is_se   = (b == B_SE);
      stat.is_cmd  = (b == B_WILL) || (b == B_WONT) || (b == B_DO) || (b == B_DONT);
      stat.is_gmcp = (b == B_GMCP);
      stat.multi   = (job_in.last_idx != '0);
      stat.at_last = (idx_ff == job_ff.last_idx);
   end

endmodule

// ===== hw/rtl/tss_ctrl.sv =====
module tss_ctrl import tss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   // Parser modes.
   localparam logic [2:0] M_NORMAL    = 3'd0;
   localparam logic [2:0] M_IAC       = 3'd1;
   localparam logic [2:0] M_CMD       = 3'd2;
   localparam logic [2:0] M_SB        = 3'd3;
   localparam logic [2:0] M_OTHER     = 3'd4;
   localparam logic [2:0] M_OTHER_IAC = 3'd5;
   localparam logic [2:0] M_GMCP      = 3'd6;
   localparam logic [2:0] M_GMCP_IAC  = 3'd7;

   // Result sequencing.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BURST = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_WR    = 3'd3;
   localparam logic [2:0] S_PUSH2 = 3'd4;

   logic [2:0] mode_ff, mode_in;
   logic [2:0] seq_ff, seq_in;
   logic       second_push;

   always_comb begin
      cmd         = '0;
      mode_in     = mode_ff;
      seq_in      = seq_ff;
      second_push = 1'b0;
      req_stall   = 1'b1;
      unique case (seq_ff)
         S_IDLE: begin
            req_stall = !stat.space;
            if (req_valid && stat.space) begin
               cmd.accept = 1'b1;
               cmd.kind   = K_NONE;
               unique case (mode_ff)
                  M_NORMAL: begin
                     if (stat.is_iac) mode_in = M_IAC;
                     else cmd.kind = K_DATA;
                  end
                  M_IAC: begin
                     priority if (stat.is_iac) begin
                        cmd.kind = K_IACIAC;
                        mode_in  = M_NORMAL;
                     end else if (stat.is_sb) begin
                        mode_in = M_SB;
                     end else if (stat.is_cmd) begin
                        cmd.hold_cmd = 1'b1;
                        mode_in      = M_CMD;
                     end else begin
                        cmd.kind = K_CMD2;
                        mode_in  = M_NORMAL;
                     end
                  end
                  M_CMD: begin
                     cmd.kind = K_CMD3;
                     mode_in  = M_NORMAL;
                  end
                  M_SB: begin
                     if (stat.is_gmcp) begin
                        mode_in = M_GMCP;
                     end else begin
                        cmd.push_op = PUSH_FIRST;
                        mode_in     = M_OTHER;
                     end
                  end
                  M_OTHER: begin
                     if (stat.is_iac) mode_in = M_OTHER_IAC;
                     else cmd.push_op = PUSH_BYTE;
                  end
                  M_OTHER_IAC: begin
                     priority if (stat.is_se) begin
                        cmd.kind      = K_REPLAY;
                        cmd.clear_cnt = 1'b1;
                        mode_in       = M_NORMAL;
                     end else if (stat.is_iac) begin
                        cmd.push_op = PUSH_IAC;
                        mode_in     = M_OTHER;
                     end else begin
                        cmd.push_op = PUSH_IAC;
                        second_push = 1'b1;
                        mode_in     = M_OTHER;
                     end
                  end
                  M_GMCP: begin
                     if (stat.is_iac) mode_in = M_GMCP_IAC;
                     else cmd.kind = K_GMCP1;
                  end
                  M_GMCP_IAC: begin
                     if (stat.is_se) begin
                        cmd.kind = K_GEND;
                        mode_in  = M_NORMAL;
                     end else begin
                        cmd.kind = K_GMCP_IAC;
                        mode_in  = M_GMCP;
                     end
                  end
               endcase
               priority if (cmd.kind == K_REPLAY) seq_in = S_RD;
               else if (second_push) seq_in = S_PUSH2;
               else if (stat.multi) seq_in = S_BURST;
               else seq_in = S_IDLE;
            end
         end
         S_BURST: begin
            if (stat.space) begin
               cmd.emit = 1'b1;
               if (stat.at_last) seq_in = S_IDLE;
            end
         end
         S_RD: begin
            seq_in = S_WR;
         end
         S_WR: begin
            if (stat.space) begin
               cmd.emit = 1'b1;
               seq_in   = stat.at_last ? S_IDLE : S_RD;
            end
         end
         S_PUSH2: begin
            cmd.push_op = PUSH_LATCHED;
            seq_in      = S_IDLE;
         end
         default: begin
            seq_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_NORMAL;
         seq_ff  <= S_IDLE;
      end else begin
         mode_ff <= mode_in;
         seq_ff  <= seq_in;
      end
   end

endmodule

// ===== hw/rtl/telnet_stream_splitter.sv =====
// Telnet stream splitter: takes one raw Telnet byte per input item on the
// req_ channel and sends result items on the rsp_ channel. Each result item
// carries a plain data byte, a GMCP byte and a charset payload byte, each
// with its own valid bit, plus the event code of the negotiation that the
// byte completed. An input item yields one or more results, and the last
// one has last_result set and echoes end_of_chunk as chunk_done.
// The csr_ channel writes strip_commands; it is always ready.
// The first result of an item that is not a replay is written to the
// output queue as the item is accepted and is on rsp_ in the next cycle,
// so plain data streams at one byte per cycle while the queue has space.
// A byte with more results holds the input until its last is queued. An
// IAC followed by a byte other than IAC or SE in a stored subnegotiation
// writes the store twice, IAC then the byte, as it has one write port. The
// closing IAC SE replays the store, per result an address, then a read.
// Reset brings the parser to plain data, clears the held command and the
// store fill count, sets strip_commands and empties the output queue.
// A two-entry output queue sits before rsp_; when the receiver stalls and
// the queue fills, req_stall rises and the parser holds its place.
module telnet_stream_splitter import tss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   // Command and status between the controller and the datapath.
   cmd_type  cmd;
   stat_type stat;

   // The controller tracks the Telnet parser mode and sequences multi-result
   // items; it never touches a data byte directly.
   tss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the store, the held command, the job of the current
   // item and the output queue.
   tss_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/tss_checker.sv =====
module tss_checker import tss_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or vanished");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item offered right after reset");

   a_gmcp_end_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.gmcp_end |->
         !rsp_data.plain_valid && !rsp_data.payload_valid && rsp_data.last_result)
      else $error("GMCP end marker shares its item with other bytes");

   a_payload_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.payload_valid |->
         (rsp_data.event_res == EV_REQUEST || rsp_data.event_res == EV_ACCEPTED))
      else $error("charset payload byte without request or accepted event");

   a_chunk_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_result |-> !rsp_data.chunk_done)
      else $error("chunk_done set on a result that is not the last");

endmodule

bind telnet_stream_splitter tss_checker u_tss_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
